// ===== src/clook_pkg.sv =====
// ----------------------------------------------------------------------------
// clook_pkg
// Shared types and default sizes for the C-LOOK request queue.
// ----------------------------------------------------------------------------
package clook_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int SECTOR_BITS_DEF = 48;
  localparam int TAG_BITS_DEF    = 8;
  localparam int FIFO_DEPTH_DEF  = 2;

  typedef enum logic {
    OP_INSERT   = 1'b0,
    OP_DISPATCH = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY
  } back_state_e;

  // result flags, highest bit first
  typedef struct packed {
    logic dispatched;
    logic queue_full;
    logic insert_done;
  } result_flags_t;

endpackage

// ===== src/clook_front.sv =====
// ----------------------------------------------------------------------------
// clook_front
// Input register: takes items from the stream, classifies the op and hands
// the packed command to the command queue.
// ----------------------------------------------------------------------------
module clook_front #(
  parameter int SECTOR_BITS = 48,
  parameter int TAG_BITS    = 8,
  localparam int CMD_W      = SECTOR_BITS + TAG_BITS + 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   in_op_i,
  input  logic [SECTOR_BITS-1:0] in_sector_i,
  input  logic [TAG_BITS-1:0]    in_tag_i,
  output logic                   cmd_valid_o,
  input  logic                   cmd_ready_i,
  output logic [CMD_W-1:0]       cmd_data_o
);
  import clook_pkg::*;

  logic                   valid_q, valid_d;
  op_e                    op_q;
  logic [SECTOR_BITS-1:0] sector_q;
  logic [TAG_BITS-1:0]    tag_q;
  logic                   take;

  assign in_ready_o = !valid_q || cmd_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // sector and tag only matter for inserts
  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q     <= op_e'(in_op_i);
      sector_q <= (op_e'(in_op_i) == OP_INSERT) ? in_sector_i : '0;
      tag_q    <= (op_e'(in_op_i) == OP_INSERT) ? in_tag_i : '0;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_data_o  = {op_q, tag_q, sector_q};

endmodule

// ===== src/clook_fifo.sv =====
// ----------------------------------------------------------------------------
// clook_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module clook_fifo #(
  parameter int DATA_W = 57,
  parameter int DEPTH  = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  logic [DATA_W-1:0] wr_data_i,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output logic [DATA_W-1:0] rd_data_o
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] buf_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              push, pop;

  assign wr_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = buf_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== src/clook_back.sv =====
// ----------------------------------------------------------------------------
// clook_back
// Sorted slot array: compares a new request against every slot, then
// shifts it into place or pops the front, and registers the result item.
// ----------------------------------------------------------------------------
module clook_back #(
  parameter int QUEUE_DEPTH = 32,
  parameter int SECTOR_BITS = 48,
  parameter int TAG_BITS    = 8,
  localparam int CMD_W      = SECTOR_BITS + TAG_BITS + 1,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cmd_valid_i,
  output logic                            cmd_ready_o,
  input  logic [CMD_W-1:0]                cmd_data_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output clook_pkg::result_flags_t        res_flags_o,
  output logic [SECTOR_BITS-1:0]          res_sector_o,
  output logic [TAG_BITS-1:0]             res_tag_o,
  output logic [CNT_W-1:0]                res_count_o
);
  import clook_pkg::*;

  logic [SECTOR_BITS-1:0] sec_q [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]    tag_q [QUEUE_DEPTH];
  logic [CNT_W-1:0]       fill_q;
  logic [SECTOR_BITS-1:0] head_q;
  back_state_e            state_q, state_d;

  op_e                    op_q;
  logic [SECTOR_BITS-1:0] new_sec_q;
  logic [TAG_BITS-1:0]    new_tag_q;

  logic [QUEUE_DEPTH-1:0] hit_q, hit_d, first, above;

  logic                   res_valid_q;
  result_flags_t          res_flags_q;
  logic [SECTOR_BITS-1:0] res_sector_q;
  logic [TAG_BITS-1:0]    res_tag_q;
  logic [CNT_W-1:0]       res_count_q;

  logic out_free, pop_cmd, do_apply, is_full, is_empty, do_ins, do_disp;

  function automatic logic goes_before(input logic [SECTOR_BITS-1:0] fresh,
                                       input logic [SECTOR_BITS-1:0] held,
                                       input logic [SECTOR_BITS-1:0] head);
    logic result;
    if (fresh > head) begin
      result = (held < head) || (fresh < held);
    end else begin
      result = (held < head) && (fresh < held);
    end
    return result;
  endfunction

  assign out_free = !res_valid_q || res_ready_i;
  assign is_full  = (fill_q == CNT_W'(QUEUE_DEPTH));
  assign is_empty = (fill_q == '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        state_d = ST_APPLY;
      end
      ST_APPLY: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    pop_cmd  = 1'b0;
    do_apply = 1'b0;
    case (state_q)
      ST_IDLE:  pop_cmd  = cmd_valid_i;
      ST_APPLY: do_apply = out_free;
      default: begin
        pop_cmd  = 1'b0;
        do_apply = 1'b0;
      end
    endcase
  end

  assign cmd_ready_o = pop_cmd;
  assign do_ins      = do_apply && (op_q == OP_INSERT) && !is_full;
  assign do_disp     = do_apply && (op_q == OP_DISPATCH) && !is_empty;

  // per-slot stop condition, with the back of the queue as fallback
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      hit_d[i] = ((CNT_W'(i) < fill_q) && goes_before(new_sec_q, sec_q[i], head_q))
                 || (CNT_W'(i) == fill_q);
    end
  end

  assign first = hit_q & (~hit_q + {{(QUEUE_DEPTH-1){1'b0}}, 1'b1});
  assign above = ~(first - {{(QUEUE_DEPTH-1){1'b0}}, 1'b1}) & ~first;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      head_q      <= '1;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (do_ins) begin
        fill_q <= fill_q + CNT_W'(1);
      end else if (do_disp) begin
        fill_q <= fill_q - CNT_W'(1);
        head_q <= sec_q[0];
      end
      if (do_apply) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_cmd) begin
      op_q      <= op_e'(cmd_data_i[CMD_W-1]);
      new_tag_q <= cmd_data_i[SECTOR_BITS +: TAG_BITS];
      new_sec_q <= cmd_data_i[SECTOR_BITS-1:0];
    end
    if (state_q == ST_CMP) begin
      hit_q <= hit_d;
    end
  end

  // slot row
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (do_ins) begin
        if (first[i]) begin
          sec_q[i] <= new_sec_q;
          tag_q[i] <= new_tag_q;
        end else if (above[i] && (i > 0)) begin
          sec_q[i] <= sec_q[(i > 0) ? i - 1 : 0];
          tag_q[i] <= tag_q[(i > 0) ? i - 1 : 0];
        end
      end else if (do_disp && (i < QUEUE_DEPTH - 1)) begin
        sec_q[i] <= sec_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
        tag_q[i] <= tag_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  // result item
  always_ff @(posedge clk_i) begin
    if (do_apply) begin
      res_flags_q.insert_done <= (op_q == OP_INSERT) && !is_full;
      res_flags_q.queue_full  <= (op_q == OP_INSERT) && is_full;
      res_flags_q.dispatched  <= do_disp;
      res_sector_q            <= do_disp ? sec_q[0] : '0;
      res_tag_q               <= do_disp ? tag_q[0] : '0;
      if (do_ins) begin
        res_count_q <= fill_q + CNT_W'(1);
      end else if (do_disp) begin
        res_count_q <= fill_q - CNT_W'(1);
      end else begin
        res_count_q <= fill_q;
      end
    end
  end

  assign res_valid_o  = res_valid_q;
  assign res_flags_o  = res_flags_q;
  assign res_sector_o = res_sector_q;
  assign res_tag_o    = res_tag_q;
  assign res_count_o  = res_count_q;

endmodule

// ===== src/clook_request_queue_top.sv =====
// An input item passes the front register and the command queue, then the compare
// and apply steps of the slot array, which serves one command at a time and takes
// no new one until the last has been applied; the result item is registered.
// Up to three more items are buffered ahead of the slot array.
// Reset: queue empty, head position all ones; slot contents are not cleared.
// ----------------------------------------------------------------------------
// clook_request_queue_top
// C-LOOK disk request queue with insert and dispatch commands.
// ----------------------------------------------------------------------------
module clook_request_queue_top #(
  parameter int QUEUE_DEPTH = clook_pkg::QUEUE_DEPTH_DEF,
  parameter int SECTOR_BITS = clook_pkg::SECTOR_BITS_DEF,
  parameter int TAG_BITS    = clook_pkg::TAG_BITS_DEF,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1),
  localparam int IN_DATA_W  = ((SECTOR_BITS + TAG_BITS + 7) / 8) * 8,
  localparam int OUT_DATA_W = ((SECTOR_BITS + TAG_BITS + CNT_W + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // sector, tag
  input  logic                  s_axis_tuser,  // op
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // out_sector, out_tag, entries_held
  output logic [2:0]            m_axis_tuser   // insert_done, queue_full, dispatched
);
  import clook_pkg::*;

  localparam int CMD_W = SECTOR_BITS + TAG_BITS + 1;

  logic                   f_valid, f_ready, q_valid, q_ready;
  logic [CMD_W-1:0]       f_data, q_data;
  result_flags_t          res_flags;
  logic [SECTOR_BITS-1:0] res_sector;
  logic [TAG_BITS-1:0]    res_tag;
  logic [CNT_W-1:0]       res_count;

  clook_front #(
    .SECTOR_BITS(SECTOR_BITS),
    .TAG_BITS   (TAG_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_op_i    (s_axis_tuser),
    .in_sector_i(s_axis_tdata[SECTOR_BITS-1:0]),
    .in_tag_i   (s_axis_tdata[SECTOR_BITS +: TAG_BITS]),
    .cmd_valid_o(f_valid),
    .cmd_ready_i(f_ready),
    .cmd_data_o (f_data)
  );

  clook_fifo #(
    .DATA_W(CMD_W),
    .DEPTH (FIFO_DEPTH_DEF)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(f_valid),
    .wr_ready_o(f_ready),
    .wr_data_i (f_data),
    .rd_valid_o(q_valid),
    .rd_ready_i(q_ready),
    .rd_data_o (q_data)
  );

  clook_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .SECTOR_BITS(SECTOR_BITS),
    .TAG_BITS   (TAG_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_data_i  (q_data),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_flags_o (res_flags),
    .res_sector_o(res_sector),
    .res_tag_o   (res_tag),
    .res_count_o (res_count)
  );

  assign m_axis_tdata = OUT_DATA_W'({res_count, res_tag, res_sector});
  assign m_axis_tuser = res_flags;

endmodule

// ===== src/clook_chk.sv =====
// ----------------------------------------------------------------------------
// clook_chk
// Port-level checks for the C-LOOK request queue, bound to the top level.
// ----------------------------------------------------------------------------
module clook_chk #(
  parameter int QUEUE_DEPTH = 32,
  parameter int SECTOR_BITS = 48,
  parameter int TAG_BITS    = 8,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1),
  localparam int OUT_DATA_W = ((SECTOR_BITS + TAG_BITS + CNT_W + 7) / 8) * 8
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [2:0]            m_axis_tuser
);
  logic [CNT_W-1:0] count;
  logic             no_payload;

  assign count      = m_axis_tdata[SECTOR_BITS + TAG_BITS +: CNT_W];
  assign no_payload = (m_axis_tdata[SECTOR_BITS + TAG_BITS - 1:0] == '0);

  a_one_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0(m_axis_tuser))
    else $error("more than one result flag set");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (count <= CNT_W'(QUEUE_DEPTH)))
    else $error("entry count above queue depth");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (count == CNT_W'(QUEUE_DEPTH)))
    else $error("refused insert while queue not full");

  a_idle_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[2]) |-> no_payload)
    else $error("sector or tag set without dispatch");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result item changed");

endmodule

bind clook_request_queue_top clook_chk #(
  .QUEUE_DEPTH(QUEUE_DEPTH),
  .SECTOR_BITS(SECTOR_BITS),
  .TAG_BITS   (TAG_BITS)
) u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
